// File: rtl/core/ssmlp_pkg.sv
`default_nettype none

package ssmlp_pkg;

  // Default network shape
  localparam int DEF_HIDDEN_COUNT = 5;
  localparam int DEF_INPUT_COUNT  = 5;
  localparam int OUT_NODES        = 3;

  // Field widths
  localparam int DATA_W   = 16;
  localparam int INDEX_W  = 6;
  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 56;

  // Bit positions inside the slave tdata
  localparam int IDX_LSB  = 0;
  localparam int WVAL_LSB = IDX_LSB + INDEX_W;
  localparam int DIST_LSB = WVAL_LSB + DATA_W;

  // Fixed-point constants
  localparam logic [DATA_W-1:0] THRESH_RESET = 16'h8000;
  localparam logic [32:0]       ONE_Q21      = 33'h0_0020_0000;
  localparam int                DIV_STEPS    = 16;

  // Command codes carried in tuser
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_INFER = 1'b1;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MAC  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_FIN  = 4'b1000
  } state_t;

endpackage

`default_nettype wire

// File: rtl/core/softsign_mlp_steering_top.sv
`default_nettype none

// Two-layer perceptron steering engine with a 16-bit weight store. A beat with
// tuser = 0 writes one Q3.13 weight (slot h*INPUT_COUNT+i for input-to-hidden,
// INPUT_COUNT*HIDDEN_COUNT + o*HIDDEN_COUNT+h for hidden-to-output; slots past
// the store depth are dropped). A beat with tuser = 1 runs
// inference on the Q8.8 distances and returns one result beat with the three
// decisions and the Q0.16 output activations. Every weight used must have been
// written first. Inference runs on one shared 16x17 multiplier with a saturating
// 32-bit accumulator and one radix-2 divider for softsign; each node runs its
// multiply-accumulate and then its division, one node after another, and
// s_axis_tready is low from the start of an inference until its result beat
// is registered.
// The threshold register may be written at any time the engine is idle.
module softsign_mlp_steering_top #(
  parameter int HIDDEN_COUNT = ssmlp_pkg::DEF_HIDDEN_COUNT,
  parameter int INPUT_COUNT  = ssmlp_pkg::DEF_INPUT_COUNT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // Threshold register
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ssmlp_pkg::DATA_W-1:0]   cfg_data,
  // Commands
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // weight_index[5:0], weight_value[21:6], dist_0..dist_4[101:22], zero pad
  input  wire logic [ssmlp_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // command
  input  wire logic                           s_axis_tuser,
  // Results
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // drive[0], turn_left[1], turn_right[2], act_drive[18:3], act_left[34:19],
  // act_right[50:35], zero pad
  output logic [ssmlp_pkg::M_TDATA_W-1:0]     m_axis_tdata
);
  import ssmlp_pkg::*;

  localparam int W_DEPTH   = INPUT_COUNT * HIDDEN_COUNT + OUT_NODES * HIDDEN_COUNT;
  localparam int W_ADDR_W  = $clog2(W_DEPTH);
  localparam int MAX_TAPS  = (INPUT_COUNT > HIDDEN_COUNT) ? INPUT_COUNT : HIDDEN_COUNT;
  localparam int K_W       = $clog2(MAX_TAPS + 1);
  localparam int MAX_NODES = (HIDDEN_COUNT > OUT_NODES) ? HIDDEN_COUNT : OUT_NODES;
  localparam int ND_W      = $clog2(MAX_NODES);
  localparam int DC_W      = $clog2(DIV_STEPS + 1);

  state_t state;

  logic [DATA_W-1:0] threshold;

  // Weight store
  logic signed [DATA_W-1:0] wmem [W_DEPTH];
  logic signed [DATA_W-1:0] w_rdata;
  logic                     wr_en;
  logic [W_ADDR_W-1:0]      rd_addr;

  // Sequencer
  logic                 layer;      // 0: hidden layer, 1: output layer
  logic [ND_W-1:0]      nd;
  logic [K_W-1:0]       k;
  logic [K_W-1:0]       rd_k;
  logic [W_ADDR_W:0]    base;
  logic [K_W-1:0]       ntaps;
  logic                 issue;
  logic                 rd_v;
  logic                 prod_v;
  logic                 mac_done;
  logic                 s_acc;
  logic                 div_last;

  // Operands and accumulator
  logic [DATA_W-1:0]        distance [INPUT_COUNT];
  logic signed [DATA_W:0]   hid  [HIDDEN_COUNT];
  logic [DATA_W-1:0]        act  [OUT_NODES];
  logic signed [DATA_W:0]   b_sel;
  logic signed [32:0]       mul_out;
  logic signed [32:0]       prod;
  logic signed [32:0]       addend;
  logic signed [33:0]       sum;
  logic signed [31:0]       acc;
  logic signed [31:0]       acc_next;
  logic [31:0]              mag;

  // Divider
  logic [32:0]         rem;
  logic [32:0]         den;
  logic [DATA_W-1:0]   q;
  logic [DC_W-1:0]     dcnt;
  logic                neg;
  logic [33:0]         rem2;
  logic                ge;
  logic signed [DATA_W:0] q_signed;

  // Decisions
  logic fire_drive;
  logic fire_left;
  logic fire_right;
  logic out_free;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;

  assign wr_en = s_acc && (s_axis_tuser == CMD_WRITE) &&
                 ({1'b0, s_axis_tdata[IDX_LSB +: INDEX_W]} < (INDEX_W + 1)'(W_DEPTH));

  // Sequencer decodes
  assign ntaps    = layer ? K_W'(HIDDEN_COUNT) : K_W'(INPUT_COUNT);
  assign issue    = (state == ST_MAC) && (k < ntaps);
  assign rd_addr  = W_ADDR_W'(base + (W_ADDR_W + 1)'(k));
  assign mac_done = (state == ST_MAC) && (k == ntaps) && !rd_v && !prod_v;
  assign div_last = (dcnt == DC_W'(DIV_STEPS));

  // Weight store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      wmem[s_axis_tdata[IDX_LSB +: W_ADDR_W]] <= s_axis_tdata[WVAL_LSB +: DATA_W];
    end
    w_rdata <= wmem[rd_addr];
  end

  // Pick the second multiplier operand for the tap in flight
  always_comb begin
    b_sel = '0;
    if (!layer) begin
      for (int j = 0; j < INPUT_COUNT; j++) begin
        if (rd_k == K_W'(j)) b_sel = {1'b0, distance[j]};
      end
    end else begin
      for (int j = 0; j < HIDDEN_COUNT; j++) begin
        if (rd_k == K_W'(j)) b_sel = hid[j];
      end
    end
  end

  assign mul_out = w_rdata * b_sel;

  // Scale output-layer products down to Q.21 (floor), then saturate the sum
  always_comb begin
    addend = layer ? (prod >>> 8) : prod;
    sum    = {acc[31], acc[31], acc} + {addend[32], addend};
    if (sum[33:31] == 3'b000 || sum[33:31] == 3'b111) begin
      acc_next = sum[31:0];
    end else if (sum[33]) begin
      acc_next = 32'sh8000_0000;
    end else begin
      acc_next = 32'sh7FFF_FFFF;
    end
    mag = acc[31] ? (~acc + 32'd1) : acc;
  end

  // One restoring division step
  always_comb begin
    rem2     = {rem, 1'b0};
    ge       = (rem2 >= {1'b0, den});
    q_signed = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
  end

  // Output decisions
  always_comb begin
    fire_drive = act[0] > threshold;
    fire_left  = (act[1] > act[2]) && (act[1] > threshold);
    fire_right = !(act[1] > act[2]) && (act[2] > threshold);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      rd_v          <= 1'b0;
      prod_v        <= 1'b0;
      m_axis_tvalid <= 1'b0;
      threshold     <= THRESH_RESET;
    end else begin
      if (cfg_valid && cfg_ready) threshold <= cfg_data;
      rd_v   <= issue;
      prod_v <= rd_v;
      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_acc && s_axis_tuser == CMD_INFER) state <= ST_MAC;
        end
        ST_MAC: begin
          if (mac_done) state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_last) begin
            if (layer && nd == ND_W'(OUT_NODES - 1)) state <= ST_FIN;
            else state <= ST_MAC;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    rd_k <= k;
    prod <= mul_out;
    if (prod_v) acc <= acc_next;
    if (issue) k <= k + K_W'(1);

    case (state)
      ST_IDLE: begin
        if (s_acc && s_axis_tuser == CMD_INFER) begin
          for (int j = 0; j < INPUT_COUNT; j++) begin
            distance[j] <= s_axis_tdata[DIST_LSB + DATA_W * j +: DATA_W];
          end
          k     <= '0;
          base  <= '0;
          nd    <= '0;
          layer <= 1'b0;
          acc   <= '0;
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          rem  <= {1'b0, mag};
          den  <= ONE_Q21 + {1'b0, mag};
          neg  <= acc[31];
          q    <= '0;
          dcnt <= '0;
        end
      end
      ST_DIV: begin
        if (!div_last) begin
          rem  <= ge ? 33'(rem2 - {1'b0, den}) : rem2[32:0];
          q    <= {q[DATA_W-2:0], ge};
          dcnt <= dcnt + DC_W'(1);
        end else begin
          // Write back the activation and advance to the next node
          if (!layer) begin
            for (int j = 0; j < HIDDEN_COUNT; j++) begin
              if (nd == ND_W'(j)) hid[j] <= q_signed;
            end
          end else begin
            for (int j = 0; j < OUT_NODES; j++) begin
              if (nd == ND_W'(j)) act[j] <= q;
            end
          end
          k    <= '0;
          acc  <= '0;
          base <= base + (W_ADDR_W + 1)'(ntaps);
          if (!layer && nd == ND_W'(HIDDEN_COUNT - 1)) begin
            layer <= 1'b1;
            nd    <= '0;
          end else begin
            nd <= nd + ND_W'(1);
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          m_axis_tdata <= {5'b0, act[2], act[1], act[0], fire_right, fire_left, fire_drive};
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTH
  // Partial remainder stays below the divisor, so each quotient bit is 0 or 1
  a_rem_below_den: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  // Division never runs past its step count
  a_div_steps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (dcnt <= DC_W'(DIV_STEPS)))
    else $error("divider step count overrun");

  // Weight reads stay inside the store
  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    issue |-> ({1'b0, rd_addr} < (W_ADDR_W + 1)'(W_DEPTH)) &&
              ((base + (W_ADDR_W + 1)'(k)) < (W_ADDR_W + 1)'(W_DEPTH)))
    else $error("weight read beyond store depth");

  // Products in flight only while accumulating
  a_prod_in_mac: assert property (@(posedge clk) disable iff (rst)
    (rd_v || prod_v) |-> (state == ST_MAC))
    else $error("product pipeline active outside accumulate");

  // A result beat appears only out of the finish state
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state == ST_FIN))
    else $error("result raised outside finish state");
`endif

endmodule

`default_nettype wire
